FILE: sv/cst_pkg.sv
// Package for the counting semaphore table: status and operation codes,
// default sizes and the controller state type. No dependencies.
`default_nettype none
package cst_pkg;
   localparam int SemSlots       = 16;
   localparam int QueueSlots     = 64;
   localparam int PerCallerLimit = 8;

   typedef enum logic [1:0] {
      FUNC_CREATE  = 2'd0,
      FUNC_WAIT    = 2'd1,
      FUNC_POST    = 2'd2,
      FUNC_RELEASE = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_BAD_ARG      = 3'd1,
      ST_NOT_IN_USE   = 3'd2,
      ST_TABLE_FULL   = 3'd3,
      ST_QUEUE_FULL   = 3'd4,
      ST_CALLER_LIMIT = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_QREAD,
      S_EXEC,
      S_DRAIN_RD,
      S_DRAIN
   } state_type;

   localparam logic signed [15:0] CountMax = 16'sh7fff;
   localparam logic signed [15:0] CountMin = 16'sh8000;
endpackage
`default_nettype wire

FILE: sv/cst_queue_ram.sv
// Wait queue storage for all semaphores: one write port, one registered
// read port. Depends on nothing.
`default_nettype none
module cst_queue_ram #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [5:0]    wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [5:0]    rd_data
);
   logic [5:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: sv/counting_semaphore_table.sv
// Counting semaphore table. Uses cst_pkg and cst_queue_ram.
//
// Start is taken when busy is low; busy also stays high while a release
// still holds its final waiter result. Create, wait and post keep busy high
// after the start transfer through the read of the slot record, the read
// of the queue entry at the head, then modify and write back, and strobe
// their single result in the next cycle; the next start can be taken in
// that same cycle. The free slot for create is found by a priority search
// over the in-use bits. A valid release keeps busy high while it drains
// its queue, since each queue entry comes through the one registered read
// port of the queue memory, and also while a waiter result is still held
// for the final strobe. Release of a bad or unused index gives no result.
// Results cannot be held off; each shows for one cycle on rsp_strobe. Slot
// records sit in a small memory; in-use bits are flip-flops that reset
// clears, so no clearing pass is needed.
`default_nettype none
module counting_semaphore_table #(
   parameter int SEM_SLOTS        = cst_pkg::SemSlots,
   parameter int QUEUE_SLOTS      = cst_pkg::QueueSlots,
   parameter int PER_CALLER_LIMIT = cst_pkg::PerCallerLimit
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [1:0]        req_func,
   input  wire logic signed [7:0] req_sem_index,
   input  wire logic signed [15:0] req_init_value,
   input  wire logic [5:0]        req_caller_proc,
   input  wire logic [3:0]        req_caller_open_count,
   output logic                   rsp_strobe,
   output logic [2:0]             rsp_status,
   output logic [3:0]             rsp_sem_number,
   output logic                   rsp_caller_blocks,
   output logic                   rsp_woken_valid,
   output logic [5:0]             rsp_woken_proc,
   output logic                   rsp_last
);
   localparam int SW = (SEM_SLOTS > 1) ? $clog2(SEM_SLOTS) : 1;
   localparam int QW = $clog2(QUEUE_SLOTS);
   localparam int AW = SW + QW;
   localparam logic [QW-1:0] QLast = QW'(QUEUE_SLOTS - 1);

   typedef struct packed {
      logic signed [15:0] count;
      logic [QW-1:0]      head;
      logic [QW-1:0]      tail;
   } rec_type;

   cst_pkg::state_type state_ff, state_in;

   // request latch
   cst_pkg::func_type  func_ff, func_in;
   logic [SW-1:0]      slot_ff, slot_in;
   logic               idx_ok_ff, idx_ok_in;
   logic signed [15:0] init_ff, init_in;
   logic [5:0]         caller_ff, caller_in;
   logic [3:0]         open_ff, open_in;

   logic [SEM_SLOTS-1:0] in_use_ff, in_use_in;
   rec_type rec_mem [SEM_SLOTS];
   rec_type rec_rd_ff;
   logic          rec_we;
   logic [SW-1:0] rec_waddr;
   rec_type       rec_wdata;
   logic [QW-1:0] head_ff, head_in;
   logic [QW-1:0] tail_ff, tail_in;
   logic          pend_ff, pend_in;  // a drained entry waits to be checked

   // outputs registered
   logic       strobe_ff, strobe_in;
   logic [2:0] status_ff, status_in;
   logic [3:0] num_ff, num_in;
   logic       blocks_ff, blocks_in;
   logic       wvalid_ff, wvalid_in;
   logic       last_ff, last_in;
   logic [5:0] wproc_ff, wproc_in;
   logic [5:0] held_ff, held_in;     // drained waiter not yet emitted
   logic       held_v_ff, held_v_in;

   logic          q_wr;
   logic [AW-1:0] q_waddr, q_raddr;
   logic [5:0]    q_rdata;

   logic               start_ok;
   logic               free_any;
   logic [SW-1:0]      free_slot;
   logic               valid_sem;
   logic signed [15:0] dec_c, inc_c;
   logic               q_full, q_empty;

   function automatic logic [QW-1:0] nxt(input logic [QW-1:0] p);
      return (p == QLast) ? '0 : p + 1'b1;
   endfunction

   cst_queue_ram #(.DEPTH(SEM_SLOTS << QW), .AW(AW)) u_queue (
      .clock  (clock),
      .wr_en  (q_wr),
      .wr_addr(q_waddr),
      .wr_data(caller_ff),
      .rd_addr(q_raddr),
      .rd_data(q_rdata)
   );

   assign busy     = (state_ff != cst_pkg::S_IDLE) || held_v_ff;
   assign start_ok = start && !busy;

   // lowest free slot
   always_comb begin
      free_any  = 1'b0;
      free_slot = '0;
      for (int i = SEM_SLOTS - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            free_any  = 1'b1;
            free_slot = SW'(i);
         end
      end
   end

   assign valid_sem = idx_ok_ff && in_use_ff[slot_ff];
   assign dec_c   = (rec_rd_ff.count > cst_pkg::CountMin) ? rec_rd_ff.count - 16'sd1
                                                          : rec_rd_ff.count;
   assign inc_c   = (rec_rd_ff.count < cst_pkg::CountMax) ? rec_rd_ff.count + 16'sd1
                                                          : rec_rd_ff.count;
   assign q_full  = (nxt(rec_rd_ff.tail) == rec_rd_ff.head);
   assign q_empty = (rec_rd_ff.head == rec_rd_ff.tail);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cst_pkg::S_IDLE:     if (start_ok) state_in = cst_pkg::S_READ;
         cst_pkg::S_READ:     state_in = cst_pkg::S_QREAD;
         cst_pkg::S_QREAD:    state_in = cst_pkg::S_EXEC;
         cst_pkg::S_EXEC: begin
            if (func_ff == cst_pkg::FUNC_RELEASE && valid_sem) begin
               state_in = cst_pkg::S_DRAIN_RD;
            end else begin
               state_in = cst_pkg::S_IDLE;
            end
         end
         cst_pkg::S_DRAIN_RD: state_in = cst_pkg::S_DRAIN;
         cst_pkg::S_DRAIN: begin
            if (head_ff == tail_ff) state_in = cst_pkg::S_IDLE;
            else                    state_in = cst_pkg::S_DRAIN_RD;
         end
         default: state_in = cst_pkg::S_IDLE;
      endcase
   end

   // memory addressing
   always_comb begin
      q_wr    = (state_ff == cst_pkg::S_EXEC) && func_ff == cst_pkg::FUNC_WAIT
                && valid_sem && dec_c < 0 && !q_full;
      q_waddr = {slot_ff, rec_rd_ff.tail};
      q_raddr = (state_ff == cst_pkg::S_QREAD) ? {slot_ff, rec_rd_ff.head}
                                                : {slot_ff, head_ff};
   end

   // outputs and data path
   always_comb begin
      func_in   = func_ff;
      slot_in   = slot_ff;
      idx_ok_in = idx_ok_ff;
      init_in   = init_ff;
      caller_in = caller_ff;
      open_in   = open_ff;
      in_use_in = in_use_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      pend_in   = pend_ff;
      strobe_in = 1'b0;
      status_in = status_ff;
      num_in    = num_ff;
      blocks_in = blocks_ff;
      wvalid_in = wvalid_ff;
      wproc_in  = wproc_ff;
      last_in   = last_ff;
      held_in   = held_ff;
      held_v_in = held_v_ff;
      rec_we    = 1'b0;
      rec_waddr = slot_ff;
      rec_wdata = '{count: dec_c, head: rec_rd_ff.head, tail: rec_rd_ff.tail};
      unique case (state_ff)
         cst_pkg::S_IDLE: begin
            if (held_v_ff) begin
               // flush held waiter once the drain is done
               strobe_in = 1'b1;
               status_in = cst_pkg::ST_OK;
               num_in    = '0;
               blocks_in = 1'b0;
               wvalid_in = 1'b1;
               wproc_in  = held_ff;
               last_in   = 1'b1;
               held_v_in = 1'b0;
            end
            if (start_ok) begin
               func_in   = cst_pkg::func_type'(req_func);
               idx_ok_in = !req_sem_index[7] && (32'(req_sem_index) < SEM_SLOTS);
               slot_in   = SW'(req_sem_index[6:0]);
               init_in   = req_init_value;
               caller_in = req_caller_proc;
               open_in   = req_caller_open_count;
            end
         end
         cst_pkg::S_EXEC: begin
            status_in = cst_pkg::ST_OK;
            num_in    = '0;
            blocks_in = 1'b0;
            wvalid_in = 1'b0;
            wproc_in  = '0;
            last_in   = 1'b1;
            unique case (func_ff)
               cst_pkg::FUNC_CREATE: begin
                  strobe_in = 1'b1;
                  if (init_ff < 0) begin
                     status_in = cst_pkg::ST_BAD_ARG;
                  end else if (32'(open_ff) >= PER_CALLER_LIMIT) begin
                     status_in = cst_pkg::ST_CALLER_LIMIT;
                  end else if (!free_any) begin
                     status_in = cst_pkg::ST_TABLE_FULL;
                  end else begin
                     in_use_in[free_slot] = 1'b1;
                     rec_we    = 1'b1;
                     rec_waddr = free_slot;
                     rec_wdata = '{count: init_ff, head: '0, tail: '0};
                     num_in    = 4'(free_slot);
                  end
               end
               cst_pkg::FUNC_RELEASE: begin
                  head_in = rec_rd_ff.head;
                  tail_in = rec_rd_ff.tail;
               end
               default: begin
                  strobe_in = 1'b1;
                  if (!idx_ok_ff) begin
                     status_in = cst_pkg::ST_BAD_ARG;
                  end else if (!in_use_ff[slot_ff]) begin
                     status_in = cst_pkg::ST_NOT_IN_USE;
                  end else if (func_ff == cst_pkg::FUNC_WAIT) begin
                     rec_we = 1'b1;
                     rec_wdata.count = dec_c;
                     if (dec_c < 0 && q_full) begin
                        status_in = cst_pkg::ST_QUEUE_FULL;
                     end else if (dec_c < 0) begin
                        blocks_in = 1'b1;
                        rec_wdata.tail = nxt(rec_rd_ff.tail);
                     end
                  end else begin
                     rec_we = 1'b1;
                     rec_wdata.count = inc_c;
                     if (inc_c <= 0 && !q_empty) begin
                        wvalid_in = 1'b1;
                        wproc_in  = q_rdata;
                        rec_wdata.head = nxt(rec_rd_ff.head);
                     end
                  end
               end
            endcase
         end
         cst_pkg::S_DRAIN_RD: begin
            // read of queue[head] issued this cycle; test emptiness
            pend_in = (head_ff != tail_ff);
            if (head_ff != tail_ff) head_in = nxt(head_ff);
         end
         cst_pkg::S_DRAIN: begin
            if (pend_ff && q_rdata != caller_ff) begin
               // emit previously held waiter, hold this one
               if (held_v_ff) begin
                  strobe_in = 1'b1;
                  status_in = cst_pkg::ST_OK;
                  num_in    = '0;
                  blocks_in = 1'b0;
                  wvalid_in = 1'b1;
                  wproc_in  = held_ff;
                  last_in   = 1'b0;
               end
               held_in   = q_rdata;
               held_v_in = 1'b1;
            end
            if (head_ff == tail_ff) begin
               in_use_in[slot_ff] = 1'b0;
               rec_we    = 1'b1;
               rec_wdata = '{count: '0, head: head_ff, tail: tail_ff};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rec_we) begin
         rec_mem[rec_waddr] <= rec_wdata;
      end
      if (state_ff == cst_pkg::S_READ) begin
         rec_rd_ff <= rec_mem[slot_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= cst_pkg::S_IDLE;
         in_use_ff <= '0;
         strobe_ff <= 1'b0;
         held_v_ff <= 1'b0;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         in_use_ff <= in_use_in;
         strobe_ff <= strobe_in;
         held_v_ff <= held_v_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      slot_ff   <= slot_in;
      idx_ok_ff <= idx_ok_in;
      init_ff   <= init_in;
      caller_ff <= caller_in;
      open_ff   <= open_in;
      head_ff   <= head_in;
      tail_ff   <= tail_in;
      status_ff <= status_in;
      num_ff    <= num_in;
      blocks_ff <= blocks_in;
      wvalid_ff <= wvalid_in;
      wproc_ff  <= wproc_in;
      last_ff   <= last_in;
      held_ff   <= held_in;
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_status        = status_ff;
   assign rsp_sem_number    = num_ff;
   assign rsp_caller_blocks = blocks_ff;
   assign rsp_woken_valid   = wvalid_ff;
   assign rsp_woken_proc    = wproc_ff;
   assign rsp_last          = last_ff;
endmodule
`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench for counting_semaphore_table: directed and random
// create, wait, post and release traffic, checked by a predicting scoreboard.
// Depends on cst_pkg and the counting_semaphore_table RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

   typedef struct {
      cst_pkg::status_type status;
      logic [3:0] sem_number;
      logic       caller_blocks;
      logic       woken_valid;
      logic [5:0] woken_proc;
      logic       last;
   } sem_rsp_type;

   class sem_scoreboard;
      bit                 in_use [cst_pkg::SemSlots];
      logic signed [15:0] count  [cst_pkg::SemSlots];
      logic [5:0]         head   [cst_pkg::SemSlots];
      logic [5:0]         tail   [cst_pkg::SemSlots];
      logic [5:0]         waiters [cst_pkg::SemSlots][cst_pkg::QueueSlots];
      sem_rsp_type        pending_rsp [$];
      int                 errors;

      function new();
         errors = 0;
         for (int s = 0; s < cst_pkg::SemSlots; s++) begin
            in_use[s] = 0;
            count[s]  = 16'sd0;
            head[s]   = 6'd0;
            tail[s]   = 6'd0;
            for (int p = 0; p < cst_pkg::QueueSlots; p++) waiters[s][p] = 6'd0;
         end
      endfunction

      task report(string msg);
         $display("MISMATCH @%0t: %s", $realtime, msg);
         errors++;
      endtask

      function void push(cst_pkg::status_type st, logic [3:0] num, logic blk,
                         logic wv, logic [5:0] wp, logic lst);
         sem_rsp_type r;
         r.status = st;
         r.sem_number = num;
         r.caller_blocks = blk;
         r.woken_valid = wv;
         r.woken_proc = wp;
         r.last = lst;
         pending_rsp.push_back(r);
      endfunction

      function void push_one(cst_pkg::status_type st);
         push(st, 4'd0, 1'b0, 1'b0, 6'd0, 1'b1);
      endfunction

      // Predict the results of one accepted transfer and advance the table.
      function void note_request(cst_pkg::func_type f, logic signed [7:0] idx,
                                 logic signed [15:0] iv, logic [5:0] caller,
                                 logic [3:0] open_cnt);
         int s;
         int n;
         logic [5:0] h;
         s = int'(idx);
         if (f == cst_pkg::FUNC_CREATE) begin
            if (iv < 0) push_one(cst_pkg::ST_BAD_ARG);
            else if (int'(open_cnt) >= cst_pkg::PerCallerLimit)
               push_one(cst_pkg::ST_CALLER_LIMIT);
            else begin
               s = 0;
               while (s < cst_pkg::SemSlots && in_use[s]) s++;
               if (s >= cst_pkg::SemSlots) push_one(cst_pkg::ST_TABLE_FULL);
               else begin
                  in_use[s] = 1;
                  count[s]  = iv;
                  head[s]   = 6'd0;
                  tail[s]   = 6'd0;
                  push(cst_pkg::ST_OK, 4'(s), 1'b0, 1'b0, 6'd0, 1'b1);
               end
            end
         end else if (f == cst_pkg::FUNC_RELEASE) begin
            if (s >= 0 && s < cst_pkg::SemSlots && in_use[s]) begin
               n = 0;
               h = head[s];
               while (h != tail[s]) begin
                  if (waiters[s][h] != caller) begin
                     push(cst_pkg::ST_OK, 4'd0, 1'b0, 1'b1, waiters[s][h], 1'b0);
                     n++;
                  end
                  h = h + 6'd1;
               end
               head[s] = h;
               in_use[s] = 0;
               count[s] = 16'sd0;
               if (n > 0) pending_rsp[pending_rsp.size() - 1].last = 1'b1;
            end
         end else if (s < 0 || s >= cst_pkg::SemSlots) begin
            push_one(cst_pkg::ST_BAD_ARG);
         end else if (!in_use[s]) begin
            push_one(cst_pkg::ST_NOT_IN_USE);
         end else if (f == cst_pkg::FUNC_WAIT) begin
            if (count[s] > cst_pkg::CountMin) count[s] = count[s] - 16'sd1;
            if (count[s] < 0) begin
               if (tail[s] + 6'd1 == head[s]) push_one(cst_pkg::ST_QUEUE_FULL);
               else begin
                  waiters[s][tail[s]] = caller;
                  tail[s] = tail[s] + 6'd1;
                  push(cst_pkg::ST_OK, 4'd0, 1'b1, 1'b0, 6'd0, 1'b1);
               end
            end else push_one(cst_pkg::ST_OK);
         end else begin
            if (count[s] < cst_pkg::CountMax) count[s] = count[s] + 16'sd1;
            if (count[s] <= 0 && head[s] != tail[s]) begin
               push(cst_pkg::ST_OK, 4'd0, 1'b0, 1'b1, waiters[s][head[s]], 1'b1);
               head[s] = head[s] + 6'd1;
            end else push_one(cst_pkg::ST_OK);
         end
      endfunction

      task check_result(sem_rsp_type got);
         sem_rsp_type exp;
         if (pending_rsp.size() == 0) begin
            report($sformatf("unexpected result status=%0d", got.status));
         end else begin
            exp = pending_rsp.pop_front();
            if (got.status !== exp.status)
               report($sformatf("status %0d, want %0d", got.status, exp.status));
            if (got.sem_number !== exp.sem_number)
               report($sformatf("sem_number %0d, want %0d", got.sem_number,
                                exp.sem_number));
            if (got.caller_blocks !== exp.caller_blocks)
               report($sformatf("caller_blocks %b, want %b", got.caller_blocks,
                                exp.caller_blocks));
            if (got.woken_valid !== exp.woken_valid)
               report($sformatf("woken_valid %b, want %b", got.woken_valid,
                                exp.woken_valid));
            if (got.woken_proc !== exp.woken_proc)
               report($sformatf("woken_proc %0d, want %0d", got.woken_proc,
                                exp.woken_proc));
            if (got.last !== exp.last)
               report($sformatf("last %b, want %b", got.last, exp.last));
         end
      endtask
   endclass

   localparam int CycleLimit = 400000;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [1:0] req_func;
   logic signed [7:0] req_sem_index;
   logic signed [15:0] req_init_value;
   logic [5:0] req_caller_proc;
   logic [3:0] req_caller_open_count;
   logic rsp_strobe;
   logic [2:0] rsp_status;
   logic [3:0] rsp_sem_number;
   logic rsp_caller_blocks;
   logic rsp_woken_valid;
   logic [5:0] rsp_woken_proc;
   logic rsp_last;

   sem_scoreboard sb;
   int cycles;
   bit idle_on;

   counting_semaphore_table i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_sem_index(req_sem_index),
      .req_init_value(req_init_value), .req_caller_proc(req_caller_proc),
      .req_caller_open_count(req_caller_open_count),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
      .rsp_sem_number(rsp_sem_number), .rsp_caller_blocks(rsp_caller_blocks),
      .rsp_woken_valid(rsp_woken_valid), .rsp_woken_proc(rsp_woken_proc),
      .rsp_last(rsp_last)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      sem_rsp_type got;
      if (!reset && rsp_strobe) begin
         got.status = cst_pkg::status_type'(rsp_status);
         got.sem_number = rsp_sem_number;
         got.caller_blocks = rsp_caller_blocks;
         got.woken_valid = rsp_woken_valid;
         got.woken_proc = rsp_woken_proc;
         got.last = rsp_last;
         sb.check_result(got);
      end
   end

   // Drive one operation from the falling edge and hold it until the transfer.
   task send(cst_pkg::func_type f, logic signed [7:0] idx, logic signed [15:0] iv,
             logic [5:0] caller, logic [3:0] open_cnt);
      @(negedge clock);
      while (idle_on && $urandom_range(0, 99) < 8) begin
         start = 0;
         @(negedge clock);
      end
      start = 1;
      req_func = f;
      req_sem_index = idx;
      req_init_value = iv;
      req_caller_proc = caller;
      req_caller_open_count = open_cnt;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(f, idx, iv, caller, open_cnt);
   endtask

   task settle();
      @(negedge clock);
      start = 0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   function automatic logic signed [7:0] pick_index();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return 8'($urandom_range(0, 5));
      if (r < 90) return 8'($urandom_range(0, 15));
      return 8'($urandom());
   endfunction

   function automatic logic [3:0] pick_open();
      return ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                         : 4'($urandom_range(0, 7));
   endfunction

   task random_item();
      int r;
      bit full;
      logic signed [15:0] iv;
      full = 1;
      for (int s = 0; s < cst_pkg::SemSlots; s++) if (!sb.in_use[s]) full = 0;
      r = $urandom_range(0, 99);
      iv = ($urandom_range(0, 1) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 3));
      if (r < 18)
         send(cst_pkg::FUNC_CREATE, 8'($urandom()), iv, 6'($urandom()), pick_open());
      else if (r < (full ? 40 : 28))
         send(cst_pkg::FUNC_RELEASE, pick_index(), 16'($urandom()),
              6'($urandom_range(0, 7)), pick_open());
      else if (r < 66)
         send(cst_pkg::FUNC_WAIT, pick_index(), 16'($urandom()),
              6'($urandom_range(0, 7)), pick_open());
      else send(cst_pkg::FUNC_POST, pick_index(), 16'($urandom()), 6'($urandom()),
                pick_open());
   endtask

   // Pile waiters on one slot past queue capacity, then drain it.
   task wait_burst();
      int s;
      s = 0;
      while (s < cst_pkg::SemSlots && sb.in_use[s]) s++;
      if (s >= cst_pkg::SemSlots) begin
         send(cst_pkg::FUNC_RELEASE, 8'sd3, 16'sd0, 6'd0, 4'd0);
         s = 3;
      end
      send(cst_pkg::FUNC_CREATE, 8'sd0, 16'sd0, 6'd1, 4'd0);
      repeat (66) send(cst_pkg::FUNC_WAIT, 8'(s), 16'($urandom()),
                       6'($urandom_range(0, 3)), pick_open());
      repeat (3) send(cst_pkg::FUNC_POST, 8'(s), 16'($urandom()), 6'($urandom()),
                      pick_open());
      send(cst_pkg::FUNC_RELEASE, 8'(s), 16'($urandom()), 6'($urandom_range(0, 3)),
           pick_open());
   endtask

   initial begin
      sb = new();
      cycles = 0;
      idle_on = 1;
      reset = 1;
      start = 0;
      req_func = cst_pkg::FUNC_CREATE;
      req_sem_index = 8'sd0;
      req_init_value = 16'sd0;
      req_caller_proc = 6'd0;
      req_caller_open_count = 4'd0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;

      send(cst_pkg::FUNC_CREATE, 8'sd0, -16'sd1, 6'd0, 4'd0);
      send(cst_pkg::FUNC_CREATE, 8'sd0, 16'sh8000, 6'd63, 4'd0);
      send(cst_pkg::FUNC_CREATE, 8'sd0, 16'sd5, 6'd2, 4'd8);
      send(cst_pkg::FUNC_CREATE, 8'sd0, 16'sd5, 6'd2, 4'd15);
      send(cst_pkg::FUNC_CREATE, 8'sd0, 16'sh7fff, 6'd3, 4'd7);
      for (int i = 1; i < cst_pkg::SemSlots; i++)
         send(cst_pkg::FUNC_CREATE, 8'sd0, 16'(i), 6'd4, 4'd0);
      send(cst_pkg::FUNC_CREATE, 8'sd0, 16'sd1, 6'd5, 4'd0);
      send(cst_pkg::FUNC_POST, 8'sd0, 16'sd0, 6'd0, 4'd0);
      send(cst_pkg::FUNC_WAIT, 8'sh80, 16'sd0, 6'd0, 4'd0);
      send(cst_pkg::FUNC_WAIT, 8'sd16, 16'sd0, 6'd0, 4'd0);
      send(cst_pkg::FUNC_POST, 8'sd127, 16'sd0, 6'd0, 4'd0);
      send(cst_pkg::FUNC_RELEASE, -8'sd1, 16'sd0, 6'd0, 4'd0);
      send(cst_pkg::FUNC_RELEASE, 8'sd0, 16'sd0, 6'd0, 4'd0);
      send(cst_pkg::FUNC_WAIT, 8'sd0, 16'sd0, 6'd0, 4'd0);
      send(cst_pkg::FUNC_POST, 8'sd0, 16'sd0, 6'd0, 4'd0);
      send(cst_pkg::FUNC_RELEASE, 8'sd0, 16'sd0, 6'd0, 4'd0);
      settle();

      for (int n = 0; n < 290; n++) begin
         idle_on = !(n >= 100 && n < 180);
         if (n == 60 || n == 220) wait_burst();
         else random_item();
         if (n == 150) settle();
      end

      @(negedge clock);
      start = 0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (sb.errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire
